[rtl/ddm_pkg.sv]
package ddm_pkg;

  // field widths
  localparam int IN_W     = 16;  // signed Q7.8 drive/turn
  localparam int LIM_W    = 15;  // unsigned Q7.8 limit/floor
  localparam int GAIN_W   = 10;  // unsigned Q2.8 turn gain
  localparam int OUT_W    = 15;  // signed millivolts
  localparam int MAG_W    = 16;  // |drive| in Q7.8
  localparam int PROD_W   = 25;  // turn cap, 2^-16 percent units
  localparam int TS_W     = 24;  // drive/turn in 2^-16 percent units
  localparam int SIDE_W   = 25;  // signed side value
  localparam int SMAG_W   = 25;  // side magnitude
  localparam int LIM120_W = 22;  // speed_limit * 120
  localparam int NUM_W    = 46;  // |side| * speed_limit * 120
  localparam int DIVN_W   = 38;  // dividend after the /256
  localparam int QBITS    = 14;  // scaled quotient bits, always below 15360

  // APB
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic [ADDR_W-3:0] REG_TURN_GAIN = 1'b0;
  localparam logic [GAIN_W-1:0] GAIN_RESET    = 10'd256;

  // conversion
  localparam int MV_PER_PCT = 120;
  localparam logic [OUT_W-1:0] MV_MAX = 15'd12000;

  // front-to-back queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic signed [SIDE_W-1:0] left;
    logic signed [SIDE_W-1:0] right;
    logic [LIM_W-1:0]         lim;
  } ddm_entry_t;

  typedef struct packed {
    logic       valid;
    ddm_entry_t entry;
  } ddm_word_t;

  function automatic logic [MAG_W-1:0] mag16(input logic signed [IN_W-1:0] v);
    return v[IN_W-1] ? MAG_W'(-v) : MAG_W'(v);
  endfunction

  function automatic logic [SMAG_W-1:0] mag25(input logic signed [SIDE_W-1:0] v);
    return v[SIDE_W-1] ? SMAG_W'(-v) : SMAG_W'(v);
  endfunction

endpackage

[rtl/ddm_front.sv]
module ddm_front import ddm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  logic signed [IN_W-1:0]   drive_term,
  input  logic signed [IN_W-1:0]   drive_request,
  input  logic signed [IN_W-1:0]   turn_term,
  input  logic [LIM_W-1:0]         speed_limit,
  input  logic [LIM_W-1:0]         cruise_floor,
  input  logic [GAIN_W-1:0]        turn_gain,
  output ddm_word_t                push,
  output logic [1:0]               inflight
);

  // stage 1: magnitudes, cap product, ramp test
  logic [MAG_W-1:0]        ad, ar;
  logic [PROD_W-1:0]       f1_prod_nxt;
  logic                    f1_ramp_nxt;

  logic                    f1_v_r;
  logic [PROD_W-1:0]       f1_prod_r;
  logic                    f1_ramp_r;
  logic [LIM_W-1:0]        f1_flo_r;
  logic [LIM_W-1:0]        f1_lim_r;
  logic signed [IN_W-1:0]  f1_d_r;
  logic signed [IN_W-1:0]  f1_t_r;

  assign ad          = mag16(drive_term);
  assign ar          = mag16(drive_request);
  // 32768 * 1023 still fits in PROD_W bits
  assign f1_prod_nxt = PROD_W'(ad) * PROD_W'(turn_gain);
  assign f1_ramp_nxt = ad < ar;

  // stage 2: floor, turn clamp, side sums
  logic [PROD_W-1:0]         flo_s, cap;
  logic signed [PROD_W:0]    capi, t26, tc26;
  logic signed [TS_W-1:0]    tc, d16;
  logic signed [SIDE_W-1:0]  f2_l_nxt, f2_r_nxt;

  logic                      f2_v_r;
  logic signed [SIDE_W-1:0]  f2_l_r, f2_r_r;
  logic [LIM_W-1:0]          f2_lim_r;

  always_comb begin
    flo_s = PROD_W'({f1_flo_r, 8'b0});
    cap   = (!f1_ramp_r && (f1_prod_r < flo_s)) ? flo_s : f1_prod_r;
    capi  = $signed({1'b0, cap});
    t26   = $signed({{2{f1_t_r[IN_W-1]}}, f1_t_r, 8'b0});
    if (t26 > capi) begin
      tc26 = capi;
    end else if (t26 < -capi) begin
      tc26 = -capi;
    end else begin
      tc26 = t26;
    end
    tc       = tc26[TS_W-1:0];
    d16      = {f1_d_r, 8'b0};
    f2_l_nxt = {d16[TS_W-1], d16} + {tc[TS_W-1], tc};
    f2_r_nxt = {d16[TS_W-1], d16} - {tc[TS_W-1], tc};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else begin
      f1_v_r <= accept;
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    f1_prod_r <= f1_prod_nxt;
    f1_ramp_r <= f1_ramp_nxt;
    f1_flo_r  <= cruise_floor;
    f1_lim_r  <= speed_limit;
    f1_d_r    <= drive_term;
    f1_t_r    <= turn_term;
    f2_l_r    <= f2_l_nxt;
    f2_r_r    <= f2_r_nxt;
    f2_lim_r  <= f1_lim_r;
  end

  assign push.valid       = f2_v_r;
  assign push.entry.left  = f2_l_r;
  assign push.entry.right = f2_r_r;
  assign push.entry.lim   = f2_lim_r;
  assign inflight         = {1'b0, f1_v_r} + {1'b0, f2_v_r};

endmodule

[rtl/ddm_queue.sv]
module ddm_queue import ddm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  ddm_word_t         push,
  output ddm_word_t         head,
  output logic [QCNT_W-1:0] count
);

  ddm_entry_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              pop;

  // back end never stalls: the head goes out whenever there is one
  assign pop = count_r != '0;

  always_comb begin
    count_nxt = count_r;
    if (push.valid && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push.valid && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push.valid) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.entry;
    end
  end

  assign head.valid = pop;
  assign head.entry = mem_r[rd_ptr_r];
  assign count      = count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QDEPTH)
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push.valid && !pop) |-> (count_r < QDEPTH))
    else $error("queue push while full");

endmodule

[rtl/ddm_back.sv]
module ddm_back import ddm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ddm_word_t               word,
  output logic                    strobe,
  output logic signed [OUT_W-1:0] left_mv,
  output logic signed [OUT_W-1:0] right_mv,
  output logic                    desat
);

  typedef struct packed {
    logic [SMAG_W-1:0] den;
    logic              desat;
    logic              neg_l;
    logic              neg_r;
    logic [OUT_W-1:0]  qu_l;
    logic [OUT_W-1:0]  qu_r;
  } tag_t;

  // B0: magnitudes, larger side, saturation test, unscaled conversion
  logic [SMAG_W-1:0]   al, ar, mx;
  logic [31:0]         pl, pr;
  tag_t                b0_tag_nxt;
  logic [LIM120_W-1:0] b0_lim120_nxt;

  logic                b0_v_r;
  tag_t                b0_tag_r;
  logic [SMAG_W-1:0]   b0_al_r, b0_ar_r;
  logic [LIM120_W-1:0] b0_lim120_r;

  always_comb begin
    al = mag25(word.entry.left);
    ar = mag25(word.entry.right);
    mx = (ar > al) ? ar : al;
    pl = 32'(al) * 32'(MV_PER_PCT);
    pr = 32'(ar) * 32'(MV_PER_PCT);
    b0_tag_nxt.den   = mx;
    b0_tag_nxt.desat = mx > SMAG_W'({word.entry.lim, 8'b0});
    b0_tag_nxt.neg_l = word.entry.left[SIDE_W-1];
    b0_tag_nxt.neg_r = word.entry.right[SIDE_W-1];
    b0_tag_nxt.qu_l  = pl[30:16];
    b0_tag_nxt.qu_r  = pr[30:16];
    b0_lim120_nxt    = LIM120_W'(word.entry.lim) * LIM120_W'(MV_PER_PCT);
  end

  // B1: dividends |side| * limit * 120 / 256
  logic [NUM_W-1:0] nl, nr;
  assign nl = NUM_W'(b0_al_r) * NUM_W'(b0_lim120_r);
  assign nr = NUM_W'(b0_ar_r) * NUM_W'(b0_lim120_r);

  // divider pipeline, index 0 is the B1 register
  logic [QBITS:0]    st_v_r;
  tag_t              st_tag_r  [QBITS+1];
  logic [DIVN_W-1:0] st_reml_r [QBITS+1];
  logic [DIVN_W-1:0] st_remr_r [QBITS+1];
  logic [QBITS-1:0]  st_ql_r   [QBITS+1];
  logic [QBITS-1:0]  st_qr_r   [QBITS+1];

  logic [DIVN_W-1:0] reml_nxt [QBITS];
  logic [DIVN_W-1:0] remr_nxt [QBITS];
  logic [QBITS-1:0]  ql_nxt   [QBITS];
  logic [QBITS-1:0]  qr_nxt   [QBITS];
  logic [DIVN_W:0]   dsh      [QBITS];
  logic [QBITS-1:0]  ge_l, ge_r;

  // stage i tries quotient bit QBITS-1-i
  always_comb begin
    for (int i = 0; i < QBITS; i++) begin
      dsh[i]      = (DIVN_W+1)'(st_tag_r[i].den) << (QBITS - 1 - i);
      ge_l[i]     = {1'b0, st_reml_r[i]} >= dsh[i];
      ge_r[i]     = {1'b0, st_remr_r[i]} >= dsh[i];
      reml_nxt[i] = ge_l[i] ? DIVN_W'({1'b0, st_reml_r[i]} - dsh[i]) : st_reml_r[i];
      remr_nxt[i] = ge_r[i] ? DIVN_W'({1'b0, st_remr_r[i]} - dsh[i]) : st_remr_r[i];
      ql_nxt[i]   = {st_ql_r[i][QBITS-2:0], ge_l[i]};
      qr_nxt[i]   = {st_qr_r[i][QBITS-2:0], ge_r[i]};
    end
  end

  // output: pick quotient, clamp, restore sign
  tag_t                    fin_tag;
  logic [OUT_W-1:0]        qsel_l, qsel_r, qc_l, qc_r;
  logic signed [OUT_W-1:0] left_nxt, right_nxt;

  logic                    out_v_r;
  logic signed [OUT_W-1:0] left_r, right_r;
  logic                    desat_r;

  always_comb begin
    fin_tag   = st_tag_r[QBITS];
    qsel_l    = fin_tag.desat ? OUT_W'(st_ql_r[QBITS]) : fin_tag.qu_l;
    qsel_r    = fin_tag.desat ? OUT_W'(st_qr_r[QBITS]) : fin_tag.qu_r;
    qc_l      = (qsel_l > MV_MAX) ? MV_MAX : qsel_l;
    qc_r      = (qsel_r > MV_MAX) ? MV_MAX : qsel_r;
    left_nxt  = fin_tag.neg_l ? -$signed(qc_l) : $signed(qc_l);
    right_nxt = fin_tag.neg_r ? -$signed(qc_r) : $signed(qc_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_v_r  <= 1'b0;
      st_v_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      b0_v_r  <= word.valid;
      st_v_r  <= {st_v_r[QBITS-1:0], b0_v_r};
      out_v_r <= st_v_r[QBITS];
    end
  end

  always_ff @(posedge clk) begin
    b0_tag_r     <= b0_tag_nxt;
    b0_al_r      <= al;
    b0_ar_r      <= ar;
    b0_lim120_r  <= b0_lim120_nxt;
    st_tag_r[0]  <= b0_tag_r;
    st_reml_r[0] <= nl[NUM_W-1:8];
    st_remr_r[0] <= nr[NUM_W-1:8];
    st_ql_r[0]   <= '0;
    st_qr_r[0]   <= '0;
    for (int i = 0; i < QBITS; i++) begin
      st_tag_r[i+1]  <= st_tag_r[i];
      st_reml_r[i+1] <= reml_nxt[i];
      st_remr_r[i+1] <= remr_nxt[i];
      st_ql_r[i+1]   <= ql_nxt[i];
      st_qr_r[i+1]   <= qr_nxt[i];
    end
    left_r  <= left_nxt;
    right_r <= right_nxt;
    desat_r <= fin_tag.desat;
  end

  assign strobe   = out_v_r;
  assign left_mv  = left_r;
  assign right_mv = right_r;
  assign desat    = desat_r;

  a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (left_r <= $signed(MV_MAX)) && (left_r >= -$signed(MV_MAX)))
    else $error("left side out of range");

  a_right_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (right_r <= $signed(MV_MAX)) && (right_r >= -$signed(MV_MAX)))
    else $error("right side out of range");

endmodule

[rtl/differential_drive_mixer_core.sv]
// Path: a word taken at a clock edge passes front stages 1 and 2, the queue, B0,
//   B1, the divider and the output register, then on out_ ports strobed for one cycle.
// Throughput: one word per cycle; the 14-stage pipelined divider and the front
//   pipeline each advance one word per clock and busy stays low in steady flow.
// Reset: synchronous, active low; clears all valids, the queue and turn_gain to 1.0.
// The receiver cannot stall: every result is shown exactly once for one cycle.
module differential_drive_mixer_core import ddm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  // command channel
  input  logic                    start,
  output logic                    busy,
  input  logic signed [IN_W-1:0]  in_drive_term,
  input  logic signed [IN_W-1:0]  in_drive_request,
  input  logic signed [IN_W-1:0]  in_turn_term,
  input  logic [LIM_W-1:0]        in_speed_limit,
  input  logic [LIM_W-1:0]        in_cruise_floor,
  // result channel
  output logic                    out_strobe,
  output logic signed [OUT_W-1:0] out_left_millivolts,
  output logic signed [OUT_W-1:0] out_right_millivolts,
  output logic                    out_desaturated,
  // APB register port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]       pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready
);

  // ------------------------------------------------------------------
  // Register file: one register, turn_gain at byte address 0.
  // Register index is paddr[2]; addresses with index 1 read as zero and
  // writes there are dropped.
  // ------------------------------------------------------------------
  logic [GAIN_W-1:0] turn_gain_r;
  logic              reg_sel;
  logic              reg_wr;

  assign reg_sel = paddr[ADDR_W-1:2] == REG_TURN_GAIN;
  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? DATA_W'(turn_gain_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_gain_r <= GAIN_RESET;
    end else if (reg_wr) begin
      turn_gain_r <= pwdata[GAIN_W-1:0];
    end
  end

  // ------------------------------------------------------------------
  // Front: two stages. Stage 1 takes |drive|, the cap product and the
  // ramp test; stage 2 applies the cruise floor, clamps turn to the cap
  // and forms both sides in 2^-16 percent units.
  // ------------------------------------------------------------------
  logic      accept;
  ddm_word_t push;
  logic [1:0] inflight;

  assign accept = start && !busy;

  ddm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .drive_term    (in_drive_term),
    .drive_request (in_drive_request),
    .turn_term     (in_turn_term),
    .speed_limit   (in_speed_limit),
    .cruise_floor  (in_cruise_floor),
    .turn_gain     (turn_gain_r),
    .push          (push),
    .inflight      (inflight)
  );

  // ------------------------------------------------------------------
  // Queue between front and back. The back end drains one word per cycle
  // so each word leaves in the cycle after its push. busy reserves a slot for each
  // word still in the front, so a push can never find the queue full.
  // ------------------------------------------------------------------
  ddm_word_t         head;
  logic [QCNT_W-1:0] q_count;
  logic [QCNT_W:0]   reserved;

  ddm_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .head  (head),
    .count (q_count)
  );

  assign reserved = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(inflight);
  assign busy     = reserved >= (QCNT_W+1)'(QDEPTH);

  // ------------------------------------------------------------------
  // Back: saturation test, dividend multiply, 14-stage restoring divider
  // for the limit / max-side scaling, then clamp to 12 V and sign.
  // Unscaled words skip the quotient and use |side| * 120 / 65536.
  // ------------------------------------------------------------------
  ddm_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .word     (head),
    .strobe   (out_strobe),
    .left_mv  (out_left_millivolts),
    .right_mv (out_right_millivolts),
    .desat    (out_desaturated)
  );

endmodule
